[rtl/core/enq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package enq_pkg;

  localparam int COORD_W   = 24;
  localparam int MAG_W     = 24;
  localparam int SQ_W      = 48;
  localparam int DIST_W    = 50;
  localparam int INDEX_W   = 20;
  localparam int CLUSTER_W = 21;
  localparam int NUM_AXES  = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic [CLUSTER_W-1:0]      cluster_t;

  typedef enum logic {
    FUNC_LOAD     = 1'b0,
    FUNC_NEIGHBOR = 1'b1
  } func_t;

  // Everything about an item except its coordinates, carried alongside the lanes.
  typedef struct packed {
    func_t    func;
    index_t   index;
    cluster_t cluster;
    logic     visited;
    logic     core;
    logic     last;
  } item_tag_t;

endpackage

`default_nettype wire

[rtl/core/enq_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface enq_item_if;
  logic            valid;
  logic            ready;
  enq_pkg::func_t  func;
  enq_pkg::index_t point_index;
  enq_pkg::coord_t coord_x;
  enq_pkg::coord_t coord_y;
  enq_pkg::coord_t coord_z;
  enq_pkg::cluster_t neighbor_cluster;
  logic            neighbor_visited;
  logic            neighbor_core;
  logic            last;

  modport source (
    output valid, func, point_index, coord_x, coord_y, coord_z,
           neighbor_cluster, neighbor_visited, neighbor_core, last,
    input  ready
  );
  modport sink (
    input  valid, func, point_index, coord_x, coord_y, coord_z,
           neighbor_cluster, neighbor_visited, neighbor_core, last,
    output ready
  );
endinterface

interface enq_result_if;
  logic              valid;
  logic              ready;
  logic              within_range;
  enq_pkg::index_t   neighbor_index;
  enq_pkg::cluster_t cluster_id;
  logic              done_res;

  modport source (
    output valid, within_range, neighbor_index, cluster_id, done_res,
    input  ready
  );
  modport sink (
    input  valid, within_range, neighbor_index, cluster_id, done_res,
    output ready
  );
endinterface

interface enq_cfg_if;
  logic           valid;
  logic           ready;
  enq_pkg::dist_t data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/core/enq_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module enq_lane (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire enq_pkg::coord_t coord,
  input  wire enq_pkg::coord_t query,
  output enq_pkg::sq_t         square
);

  logic signed [enq_pkg::COORD_W:0] diff;
  logic [enq_pkg::COORD_W:0]        mag_full;
  logic [enq_pkg::MAG_W-1:0]        mag;

  always_comb begin
    diff     = {coord[enq_pkg::COORD_W-1], coord} - {query[enq_pkg::COORD_W-1], query};
    mag_full = diff[enq_pkg::COORD_W] ? 25'(-diff) : 25'(diff);
    // The magnitude is at most 2^24 - 1, so the top bit is always clear.
    mag      = mag_full[enq_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      square <= mag * mag;
    end
  end

endmodule

`default_nettype wire

[rtl/core/enq_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module enq_merge #(
  parameter int DIMS = 3
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire enq_pkg::sq_t   squares [DIMS],
  input  wire enq_pkg::dist_t eps,
  output logic                in_range
);

  logic [enq_pkg::DIST_W+1:0] total;
  enq_pkg::dist_t             dist_sat;

  always_comb begin
    total = '0;
    for (int d = 0; d < DIMS; d++) begin
      total = total + (enq_pkg::DIST_W+2)'(squares[d]);
    end
    // Saturate at the top of the distance range; three axes never get there.
    dist_sat = (total[enq_pkg::DIST_W+1:enq_pkg::DIST_W] != 2'b00) ? '1
                                                                   : total[enq_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_range <= (dist_sat <= eps);
    end
  end

endmodule

`default_nettype wire

[rtl/core/epsilon_neighborhood_query_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Modport  Carries
// item      sink     load or neighbor candidate: func, index, coordinates, flags, last
// result    source   within_range, neighbor_index, cluster_id, done_res
// cfg       sink     eps_squared write data (the one register)
//
// One item is taken every cycle unless the output stalls; a result is offered once its
// item has passed the lane, merge and output registers. The rate is set by the running
// cluster id, compared and updated once per item in the final stage, after one lane per
// axis squares its difference and the merge stage sums and compares with eps_squared.
// Reset is synchronous: it empties the pipeline and clears eps_squared, the query
// point and the running id. A stalled stage holds while the stage ahead is full.

module epsilon_neighborhood_query_unit #(
  parameter int DIMS       = 3,
  parameter int INDEX_BITS = 20
) (
  input  wire logic     clk,
  input  wire logic     rst,
  enq_item_if.sink      item,
  enq_result_if.source  result,
  enq_cfg_if.sink       cfg
);

  localparam int KEEP_BITS = (INDEX_BITS >= enq_pkg::INDEX_W) ? enq_pkg::INDEX_W : INDEX_BITS;

  enq_pkg::dist_t     eps_squared;
  enq_pkg::coord_t    query_coords [DIMS];
  enq_pkg::coord_t    item_coords [enq_pkg::NUM_AXES];
  enq_pkg::sq_t       squares [DIMS];
  enq_pkg::cluster_t  running_cluster;
  enq_pkg::cluster_t  running_cluster_next;
  enq_pkg::index_t    idx_mask;
  enq_pkg::item_tag_t item_tag;
  enq_pkg::item_tag_t s1_tag;
  enq_pkg::item_tag_t s2_tag;

  logic s1_valid;
  logic s2_valid;
  logic out_valid;
  logic s2_within;
  logic out_slot_free;
  logic s2_ready;
  logic s1_ready;
  logic item_fire;
  logic s2_fire;
  logic is_load;

  logic              out_within_range;
  enq_pkg::index_t   out_neighbor_index;
  enq_pkg::cluster_t out_cluster_id;
  logic              out_done_res;

  // Configuration is always accepted.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps_squared <= '0;
    end else if (cfg.valid && cfg.ready) begin
      eps_squared <= cfg.data;
    end
  end

  // Each stage moves on when it is empty or the stage ahead can take its item.
  assign out_slot_free = !out_valid || result.ready;
  assign s2_ready      = !s2_valid || out_slot_free;
  assign s1_ready      = !s1_valid || s2_ready;
  assign item.ready    = s1_ready;
  assign item_fire     = item.valid && item.ready;
  assign s2_fire       = s2_valid && out_slot_free;

  assign item_coords[0] = item.coord_x;
  assign item_coords[1] = item.coord_y;
  assign item_coords[2] = item.coord_z;

  always_comb begin
    item_tag.func    = item.func;
    item_tag.index   = item.point_index;
    item_tag.cluster = item.neighbor_cluster;
    item_tag.visited = item.neighbor_visited;
    item_tag.core    = item.neighbor_core;
    item_tag.last    = item.last;
  end

  // A load takes effect on the query point at once, so a neighbor in the very
  // next cycle already sees it.
  for (genvar d = 0; d < DIMS; d++) begin : g_lane
    always_ff @(posedge clk) begin
      if (rst) begin
        query_coords[d] <= '0;
      end else if (item_fire && item.func == enq_pkg::FUNC_LOAD) begin
        query_coords[d] <= item_coords[d];
      end
    end

    enq_lane u_lane (
      .clk    (clk),
      .en     (item_fire),
      .coord  (item_coords[d]),
      .query  (query_coords[d]),
      .square (squares[d])
    );
  end

  enq_merge #(
    .DIMS (DIMS)
  ) u_merge (
    .clk      (clk),
    .en       (s1_valid && s2_ready),
    .squares  (squares),
    .eps      (eps_squared),
    .in_range (s2_within)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= item.valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_tag <= item_tag;
    end
    if (s1_valid && s2_ready) begin
      s2_tag <= s1_tag;
    end
  end

  always_comb begin
    for (int b = 0; b < enq_pkg::INDEX_W; b++) begin
      idx_mask[b] = (b < KEEP_BITS);
    end
  end

  assign is_load = (s2_tag.func == enq_pkg::FUNC_LOAD);

  always_comb begin
    running_cluster_next = running_cluster;
    if (is_load) begin
      running_cluster_next = {1'b0, s2_tag.index} + enq_pkg::CLUSTER_W'(1);
    end else if (s2_within && s2_tag.visited && s2_tag.core &&
                 s2_tag.cluster < running_cluster) begin
      running_cluster_next = s2_tag.cluster;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_cluster <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (s2_fire) begin
        running_cluster <= running_cluster_next;
      end
      if (out_slot_free) begin
        // A load gives a result only when it closes a query with no neighbors.
        out_valid <= s2_valid && (!is_load || s2_tag.last);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_within_range   <= !is_load && s2_within;
      out_neighbor_index <= is_load ? '0 : (s2_tag.index & idx_mask);
      out_cluster_id     <= running_cluster_next;
      out_done_res       <= s2_tag.last;
    end
  end

  assign result.valid          = out_valid;
  assign result.within_range   = out_within_range;
  assign result.neighbor_index = out_neighbor_index;
  assign result.cluster_id     = out_cluster_id;
  assign result.done_res       = out_done_res;

endmodule

`default_nettype wire

[rtl/core/enq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module enq_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_ready,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire logic              result_within_range,
  input wire enq_pkg::index_t   result_neighbor_index,
  input wire enq_pkg::cluster_t result_cluster_id,
  input wire logic              result_done_res,
  input wire logic              cfg_ready
);

  // A result that is held back keeps its value until it is transferred.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_within_range) && $stable(result_neighbor_index) &&
      $stable(result_cluster_id) && $stable(result_done_res))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid straight after reset");

  // With the output register empty, every stage behind it can move.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with an empty output");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration write refused");

endmodule

bind epsilon_neighborhood_query_unit enq_checker u_enq_checker (
  .clk                   (clk),
  .rst                   (rst),
  .item_ready            (item.ready),
  .result_valid          (result.valid),
  .result_ready          (result.ready),
  .result_within_range   (result.within_range),
  .result_neighbor_index (result.neighbor_index),
  .result_cluster_id     (result.cluster_id),
  .result_done_res       (result.done_res),
  .cfg_ready             (cfg.ready)
);

`default_nettype wire

[tb/sv/epsilon_neighborhood_query_unit_tb.sv]
`timescale 1ns / 1ps

module epsilon_neighborhood_query_unit_tb;
  import enq_pkg::*;

  localparam int     DIMS         = 3;
  localparam int     INDEX_BITS   = 20;
  localparam int     HALF_PERIOD  = 6;
  localparam int     DRAIN_CYCLES = 6;
  localparam int     RANDOM_ITEMS = 900;
  localparam int     PHASE_ITEMS  = 150;
  localparam int     MAX_SHOWN    = 40;
  localparam int     CLUSTER_TOP  = 1 << INDEX_W;
  localparam longint RUN_LIMIT_NS = 3_000_000;
  localparam dist_t  EPS_MAX      = '1;
  localparam coord_t COORD_MAX    = 24'sh7FFFFF;
  localparam coord_t COORD_MIN    = 24'sh800000;

  typedef struct {
    func_t    func;
    index_t   index;
    coord_t   coord [NUM_AXES];
    cluster_t cluster;
    logic     visited;
    logic     core;
    logic     last;
  } query_item_t;

  typedef struct {
    logic     in_range;
    index_t   index;
    cluster_t cluster;
    logic     done;
  } region_result_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  // Tracks the query point, the running cluster id and eps, and holds the results that
  // the block still owes.
  class region_query_tracker;
    coord_t         query_point [NUM_AXES];
    cluster_t       running_id;
    dist_t          eps_sq;
    region_result_t expected_results [$];
    int             errors;

    function new();
      foreach (query_point[a]) query_point[a] = '0;
      running_id = '0;
      eps_sq     = '0;
      errors     = 0;
    endfunction

    function void set_eps(dist_t value);
      eps_sq = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void add_expected(region_result_t r);
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void note_item(query_item_t it);
      region_result_t r;
      longint         diff;
      longint         dist_sum;
      if (it.func == FUNC_LOAD) begin
        query_point = it.coord;
        running_id  = cluster_t'(it.index) + cluster_t'(1);
        if (it.last) begin
          r.in_range = 1'b0;
          r.index    = '0;
          r.cluster  = running_id;
          r.done     = 1'b1;
          add_expected(r);
        end
        return;
      end
      dist_sum = 0;
      for (int a = 0; a < DIMS && a < NUM_AXES; a++) begin
        diff = longint'(it.coord[a]) - longint'(query_point[a]);
        dist_sum += diff * diff;
        if (dist_sum > longint'(EPS_MAX)) dist_sum = longint'(EPS_MAX);
      end
      r.in_range = (dist_sum <= longint'(eps_sq));
      if (r.in_range && it.visited && it.core && it.cluster < running_id)
        running_id = it.cluster;
      r.index   = it.index;
      r.cluster = running_id;
      r.done    = it.last;
      add_expected(r);
    endfunction

    task report(string what);
      if (errors < MAX_SHOWN) $display("%0t ns mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(region_result_t got);
      region_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result for index %0d with none outstanding", got.index));
        return;
      end
      want = expected_results.pop_front();
      if (got.in_range !== want.in_range)
        report($sformatf("within_range %b, expected %b (index %0d)",
                         got.in_range, want.in_range, want.index));
      if (got.index !== want.index)
        report($sformatf("neighbor_index %0d, expected %0d", got.index, want.index));
      if (got.cluster !== want.cluster)
        report($sformatf("cluster_id %0d, expected %0d (index %0d)",
                         got.cluster, want.cluster, want.index));
      if (got.done !== want.done)
        report($sformatf("done_res %b, expected %b (index %0d)",
                         got.done, want.done, want.index));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  enq_item_if   item_ch ();
  enq_result_if result_ch ();
  enq_cfg_if    cfg_ch ();

  region_query_tracker tracker = new();

  int     burst_left  = 0;
  int     random_sent = 0;
  coord_t centre [NUM_AXES] = '{default: '0};
  index_t query_idx = '0;

  epsilon_neighborhood_query_unit #(
    .DIMS       (DIMS),
    .INDEX_BITS (INDEX_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic query_item_t make_item(func_t f, index_t idx, coord_t x, coord_t y,
                                            coord_t z, cluster_t ncl, logic vis, logic cr,
                                            logic lst);
    query_item_t it;
    it.func     = f;
    it.index    = idx;
    it.coord[0] = x;
    it.coord[1] = y;
    it.coord[2] = z;
    it.cluster  = ncl;
    it.visited  = vis;
    it.core     = cr;
    it.last     = lst;
    return it;
  endfunction

  function automatic coord_t near_coord(coord_t base, int scale);
    longint v;
    v = longint'($urandom_range(0, 1 << scale));
    if ($urandom_range(0, 1) == 1) v = -v;
    v += longint'(base);
    if (v > longint'(COORD_MAX)) v = longint'(COORD_MAX);
    if (v < longint'(COORD_MIN)) v = longint'(COORD_MIN);
    return coord_t'(v);
  endfunction

  function automatic query_item_t random_neighbour(int scale, logic lst);
    query_item_t it;
    int          kind;
    int          spread;
    logic        both;
    it.func  = FUNC_NEIGHBOR;
    it.index = index_t'($urandom);
    kind     = $urandom_range(0, 9);
    foreach (it.coord[a]) begin
      if (kind == 0) it.coord[a] = centre[a];
      else if (kind == 1) it.coord[a] = coord_t'($urandom);
      else it.coord[a] = near_coord(centre[a], scale);
    end
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      it.cluster = cluster_t'($urandom_range(0, CLUSTER_TOP));
    end else if (kind < 7) begin
      it.cluster = cluster_t'($urandom_range(0, 64));
    end else begin
      // At or just under the running id, so that the minimum moves in small steps.
      spread     = (query_idx < 16) ? int'(query_idx) : 16;
      it.cluster = cluster_t'(query_idx) + cluster_t'(1) - cluster_t'($urandom_range(0, spread));
    end
    both       = 1'($urandom_range(0, 1));
    it.visited = both | 1'($urandom_range(0, 1));
    it.core    = both | 1'($urandom_range(0, 1));
    it.last    = lst;
    return it;
  endfunction

  // Offers one item and returns once its transfer has taken place.
  task automatic send_item(input query_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        item_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    item_ch.valid            <= 1'b1;
    item_ch.func             <= it.func;
    item_ch.point_index      <= it.index;
    item_ch.coord_x          <= it.coord[0];
    item_ch.coord_y          <= it.coord[1];
    item_ch.coord_z          <= it.coord[2];
    item_ch.neighbor_cluster <= it.cluster;
    item_ch.neighbor_visited <= it.visited;
    item_ch.neighbor_core    <= it.core;
    item_ch.last             <= it.last;
    do @(posedge clk); while (!item_ch.ready);
    tracker.note_item(it);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_eps(input dist_t value);
    hold_until_drained();
    // A load without last leaves nothing to wait for, so give the pipeline time to empty.
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.set_eps(value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_query(input int scale, input bit pause_inside);
    query_item_t it;
    int          roll;
    int          count;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // Neighbours with no load of their own use whatever query is left over.
      repeat ($urandom_range(1, 3)) begin
        send_item(random_neighbour(scale, 1'($urandom_range(0, 3) == 0)));
        random_sent++;
      end
      return;
    end
    query_idx = ($urandom_range(0, 19) == 0) ? '1 : index_t'($urandom);
    foreach (centre[a]) begin
      if ($urandom_range(0, 1) == 1) centre[a] = coord_t'($urandom);
      else centre[a] = coord_t'(int'($urandom_range(0, 4096)) - 2048);
    end
    it         = random_neighbour(scale, 1'b0);
    it.func    = FUNC_LOAD;
    it.index   = query_idx;
    it.coord   = centre;
    it.last    = (roll < 14);
    send_item(it);
    random_sent++;
    if (it.last) return;
    count = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      send_item(random_neighbour(scale, 1'(i == count - 1 && $urandom_range(0, 6) != 0)));
      random_sent++;
      if (pause_inside && i == 0) hold_until_drained();
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        send_item(random_neighbour(scale, 1'($urandom_range(0, 1))));
        random_sent++;
      end
    end
  endtask

  initial begin : result_receiver
    rx_mode_t mode;
    int       span;
    result_ch.ready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 96);
      for (int tick = 0; tick < span; tick++) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:     result_ch.ready <= 1'b1;
          RX_RANDOM:   result_ch.ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: result_ch.ready <= ((tick % 7) < 3);
          default:     result_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    region_result_t seen;
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen.in_range = result_ch.within_range;
      seen.index    = result_ch.neighbor_index;
      seen.cluster  = result_ch.cluster_id;
      seen.done     = result_ch.done_res;
      tracker.check_result(seen);
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL epsilon_neighborhood_query_unit");
    $finish;
  end

  initial begin
    dist_t eps;
    int    phase;
    int    phase_start;
    int    pause_slot;
    int    scale;
    int    e;
    int    q;
    item_ch.valid            = 1'b0;
    item_ch.func             = FUNC_LOAD;
    item_ch.point_index      = '0;
    item_ch.coord_x          = '0;
    item_ch.coord_y          = '0;
    item_ch.coord_z          = '0;
    item_ch.neighbor_cluster = '0;
    item_ch.neighbor_visited = 1'b0;
    item_ch.neighbor_core    = 1'b0;
    item_ch.last             = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.data              = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero radius: only exact matches are in range.
    write_eps('0);
    send_item(make_item(FUNC_NEIGHBOR, 9, 0, 0, 0, 5, 1, 1, 0));
    send_item(make_item(FUNC_LOAD, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_NEIGHBOR, 1, 0, 0, 0, 0, 1, 1, 0));
    send_item(make_item(FUNC_LOAD, '1, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0));
    send_item(make_item(FUNC_NEIGHBOR, 2, COORD_MIN, COORD_MIN, COORD_MIN, 0, 1, 1, 0));
    send_item(make_item(FUNC_NEIGHBOR, 3, COORD_MAX, COORD_MAX, COORD_MAX,
                        cluster_t'(CLUSTER_TOP), 1, 1, 0));
    send_item(make_item(FUNC_NEIGHBOR, 4, COORD_MAX, COORD_MAX, COORD_MAX, 3, 1, 0, 0));
    send_item(make_item(FUNC_NEIGHBOR, 5, COORD_MAX, COORD_MAX, COORD_MAX, 3, 0, 1, 0));
    send_item(make_item(FUNC_NEIGHBOR, '1, COORD_MAX, COORD_MAX, COORD_MAX, 7, 1, 1, 1));
    send_item(make_item(FUNC_NEIGHBOR, 6, COORD_MAX, COORD_MAX, COORD_MAX, 2, 1, 1, 0));
    send_item(make_item(FUNC_LOAD, 5, 0, 0, 0, 0, 0, 0, 1));

    // Widest radius against opposite corners of the coordinate space.
    write_eps(EPS_MAX);
    send_item(make_item(FUNC_LOAD, 100, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 0));
    send_item(make_item(FUNC_NEIGHBOR, 101, COORD_MAX, COORD_MAX, COORD_MAX, 50, 1, 1, 1));

    // The bound is inclusive: a distance of exactly 25 is in, 26 is out.
    write_eps(25);
    send_item(make_item(FUNC_LOAD, 200, -100, 7, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_NEIGHBOR, 201, -97, 11, 0, 10, 1, 1, 0));
    send_item(make_item(FUNC_NEIGHBOR, 202, -97, 11, 1, 1, 1, 1, 0));
    send_item(make_item(FUNC_NEIGHBOR, 203, -103, 3, 0, 1, 1, 1, 1));

    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase % 6)
        0: begin
          eps   = EPS_MAX;
          scale = 24;
        end
        1: begin
          eps   = '0;
          scale = 1;
        end
        default: begin
          e     = $urandom_range(0, DIST_W - 1);
          eps   = (dist_t'(1) << e) | (dist_t'({$urandom, $urandom}) & ((dist_t'(1) << e) - 1));
          // Offsets near the square root of eps give a fair mix of hits and misses.
          scale = e / 2 + $urandom_range(0, 3) - 2;
          if (scale < 0) scale = 0;
          if (scale > 24) scale = 24;
        end
      endcase
      write_eps(eps);
      phase_start = random_sent;
      pause_slot  = $urandom_range(0, 4);
      q           = 0;
      while (random_sent - phase_start < PHASE_ITEMS && random_sent < RANDOM_ITEMS) begin
        random_query(scale, q == pause_slot);
        q++;
      end
      phase++;
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("PASS epsilon_neighborhood_query_unit");
    else
      $display("FAIL epsilon_neighborhood_query_unit");
    $finish;
  end

endmodule

[epsilon_neighborhood_query_unit.f]
rtl/core/enq_pkg.sv
rtl/core/enq_ifs.sv
rtl/core/enq_lane.sv
rtl/core/enq_merge.sv
rtl/core/epsilon_neighborhood_query_unit.sv
rtl/core/enq_checker.sv
tb/sv/epsilon_neighborhood_query_unit_tb.sv
